>>> design/ecu_pkg.sv
package ecu_pkg;

    localparam int REG_COUNT_DEF = 8;
    localparam int MEM_DEPTH_DEF = 256;

    localparam logic [3:0] MODE_ST   = 4'd0;
    localparam logic [3:0] MODE_LD   = 4'd1;
    localparam logic [3:0] MODE_STS  = 4'd2;
    localparam logic [3:0] MODE_LDS  = 4'd3;
    localparam logic [3:0] MODE_CALL = 4'd4;
    localparam logic [3:0] MODE_RET  = 4'd5;
    localparam logic [3:0] MODE_CLC  = 4'd6;
    localparam logic [3:0] MODE_SEC  = 4'd7;
    localparam logic [3:0] MODE_ROR  = 4'd8;
    localparam logic [3:0] MODE_ROL  = 4'd9;

    localparam int FLAG_V = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    localparam int DATA_MSB = 7;
    localparam int DATA_MSB_M1 = 6;

    typedef struct packed {
        logic [7:0] pc;
        logic [3:0] flags;
        logic       mem_we;
        logic       mem_re;
        logic       pc_from_mem;
        logic       reg_from_mem;
        logic       reg_we;
        logic [7:0] mem_addr;
        logic [7:0] data;
        logic [7:0] reg_value;
    } ecu_result_t;

    typedef struct packed {
        logic       en;
        logic [7:0] value;
    } ecu_fwd_t;

endpackage

>>> design/ecu_regfile.sv
module ecu_regfile #(
    parameter int REG_COUNT = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         we,
    input  logic [$clog2(REG_COUNT)-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [$clog2(REG_COUNT)-1:0] raddr_a,
    input  logic [$clog2(REG_COUNT)-1:0] raddr_b,
    input  ecu_pkg::ecu_fwd_t            fwd_a,
    input  ecu_pkg::ecu_fwd_t            fwd_b,
    output logic [7:0]                   rdata_a,
    output logic [7:0]                   rdata_b
);
    import ecu_pkg::*;

    logic [7:0] regs_reg [REG_COUNT];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                regs_reg[i] <= 8'd0;
            end
        end else if (we) begin
            regs_reg[waddr] <= wdata;
        end
    end

    // A forwarded value stands for a write that has not reached the array yet.
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_a_reg <= fwd_a.en ? fwd_a.value : regs_reg[raddr_a];
            rd_b_reg <= fwd_b.en ? fwd_b.value : regs_reg[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> design/ecu_dmem.sv
module ecu_dmem #(
    parameter int MEM_DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         we,
    input  logic [$clog2(MEM_DEPTH)-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [$clog2(MEM_DEPTH)-1:0] raddr,
    output logic [7:0]                   rdata
);
    import ecu_pkg::*;

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [7:0]           rd_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_reg <= mem[raddr];
        end
    end

    // An entry that was never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : 8'd0;

endmodule

>>> design/ecu_exec.sv
module ecu_exec #(
    parameter int MEM_DEPTH = 256
) (
    input  logic [3:0]                   mode,
    input  logic [7:0]                   op_a,
    input  logic [7:0]                   op_b,
    input  logic [7:0]                   immediate,
    input  logic [7:0]                   next_pc,
    input  logic [3:0]                   flags_in,
    input  logic [$clog2(MEM_DEPTH)-1:0] sp_in,
    output logic [$clog2(MEM_DEPTH)-1:0] sp_next,
    output ecu_pkg::ecu_result_t         res
);
    import ecu_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    function automatic logic [255:0][AW-1:0] build_wrap();
        logic [255:0][AW-1:0] t;
        for (int i = 0; i < 256; i++) begin
            t[i] = AW'(i % MEM_DEPTH);
        end
        return t;
    endfunction

    localparam logic [255:0][AW-1:0] ADDR_WRAP = build_wrap();

    logic [7:0] rot;

    always_comb begin
        res             = '0;
        res.pc          = next_pc;
        res.flags       = flags_in;
        res.reg_value   = op_a;
        sp_next         = sp_in;
        rot             = 8'd0;
        case (mode)
            MODE_ST, MODE_STS: begin
                res.mem_addr = 8'(ADDR_WRAP[(mode == MODE_ST) ? op_b : immediate]);
                res.data     = op_a;
                res.mem_we   = 1'b1;
            end
            MODE_LD, MODE_LDS: begin
                res.mem_addr     = 8'(ADDR_WRAP[(mode == MODE_LD) ? op_b : immediate]);
                res.mem_re       = 1'b1;
                res.reg_from_mem = 1'b1;
                res.reg_we       = 1'b1;
            end
            MODE_CALL: begin
                res.mem_addr = 8'(sp_in);
                res.data     = next_pc;
                res.mem_we   = 1'b1;
                res.pc       = immediate;
                sp_next      = (sp_in == '0) ? AW'(MEM_DEPTH - 1) : sp_in - 1'b1;
            end
            MODE_RET: begin
                sp_next         = (sp_in == AW'(MEM_DEPTH - 1)) ? '0 : sp_in + 1'b1;
                res.mem_addr    = 8'(sp_next);
                res.mem_re      = 1'b1;
                res.pc_from_mem = 1'b1;
            end
            MODE_CLC: begin
                res.flags[FLAG_C] = 1'b0;
            end
            MODE_SEC: begin
                res.flags[FLAG_C] = 1'b1;
            end
            MODE_ROR: begin
                rot               = {flags_in[FLAG_C], op_a[DATA_MSB:1]};
                res.flags[FLAG_V] = op_a[DATA_MSB] ^ flags_in[FLAG_C];
                res.flags[FLAG_N] = flags_in[FLAG_C];
                res.flags[FLAG_Z] = (rot == 8'd0);
                res.flags[FLAG_C] = op_a[0];
                res.reg_value     = rot;
                res.reg_we        = 1'b1;
            end
            MODE_ROL: begin
                rot               = {op_a[DATA_MSB_M1:0], flags_in[FLAG_C]};
                res.flags[FLAG_V] = op_a[DATA_MSB] ^ op_a[DATA_MSB_M1];
                res.flags[FLAG_N] = op_a[DATA_MSB_M1];
                res.flags[FLAG_Z] = (rot == 8'd0);
                res.flags[FLAG_C] = op_a[DATA_MSB];
                res.reg_value     = rot;
                res.reg_we        = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> design/eight_bit_cpu_execute_unit_core.sv
// An accepted item is registered in the input stage and moves on to the result stage when that stage is free.
// Throughput: one item per cycle while m_ready is high; the input stage and the result stage hold one item each.
// The data memory read port is registered, so loads and returns finish in the result stage.
// Reset: synchronous, active low; registers, flags and memory valid bits clear, the stack
// pointer goes to the top of memory, and the block is ready in the first cycle after reset.
module eight_bit_cpu_execute_unit_core #(
    parameter int REG_COUNT = ecu_pkg::REG_COUNT_DEF,
    parameter int MEM_DEPTH = ecu_pkg::MEM_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_mode,
    input  logic [2:0] s_reg_a,
    input  logic [2:0] s_reg_b,
    input  logic [7:0] s_immediate,
    input  logic [7:0] s_next_pc,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_pc_out,
    output logic [3:0] m_flags,
    output logic       m_mem_write,
    output logic [7:0] m_mem_address,
    output logic [7:0] m_mem_data,
    output logic [7:0] m_reg_value
);
    import ecu_pkg::*;

    localparam int RIW = $clog2(REG_COUNT);
    localparam int AW  = $clog2(MEM_DEPTH);

    function automatic logic [7:0][RIW-1:0] build_reg_wrap();
        logic [7:0][RIW-1:0] t;
        for (int i = 0; i < 8; i++) begin
            t[i] = RIW'(i % REG_COUNT);
        end
        return t;
    endfunction

    localparam logic [7:0][RIW-1:0] REG_WRAP = build_reg_wrap();

    logic           s1_valid_reg;
    logic [3:0]     s1_mode_reg;
    logic [RIW-1:0] s1_ra_reg;
    logic [7:0]     s1_imm_reg;
    logic [7:0]     s1_npc_reg;
    logic           a_pend_reg;
    logic           b_pend_reg;

    logic           s2_valid_reg;
    ecu_result_t    s2_res_reg;
    logic [RIW-1:0] s2_ra_reg;

    logic [3:0]     flags_reg;
    logic [AW-1:0]  sp_reg;
    logic [AW-1:0]  sp_next;

    logic           s2_free;
    logic           s1_adv;
    logic           s_acc;
    logic [RIW-1:0] ra_in;
    logic [RIW-1:0] rb_in;
    logic [7:0]     rd_a;
    logic [7:0]     rd_b;
    logic [7:0]     op_a;
    logic [7:0]     op_b;
    logic [7:0]     mem_rdata;
    logic [7:0]     s2_reg_value;
    ecu_result_t    ex;
    ecu_fwd_t       fwd_a;
    ecu_fwd_t       fwd_b;
    logic           s1_hit_a;
    logic           s1_hit_b;
    logic           s2_hit_a;
    logic           s2_hit_b;

    assign s2_free = !s2_valid_reg || m_ready;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s_ready = !s1_valid_reg || s2_free;
    assign s_acc   = s_valid && s_ready;

    assign ra_in = REG_WRAP[s_reg_a];
    assign rb_in = REG_WRAP[s_reg_b];

    assign s2_reg_value = s2_res_reg.reg_from_mem ? mem_rdata : s2_res_reg.reg_value;

    // A load still in the input stage has no data yet; the next item picks it up
    // from the result stage, where that load then sits.
    assign s1_hit_a = s1_valid_reg && ex.reg_we && (s1_ra_reg == ra_in);
    assign s1_hit_b = s1_valid_reg && ex.reg_we && (s1_ra_reg == rb_in);
    assign s2_hit_a = s2_valid_reg && s2_res_reg.reg_we && (s2_ra_reg == ra_in);
    assign s2_hit_b = s2_valid_reg && s2_res_reg.reg_we && (s2_ra_reg == rb_in);

    assign fwd_a.en    = s1_hit_a || s2_hit_a;
    assign fwd_a.value = s1_hit_a ? ex.reg_value : s2_reg_value;
    assign fwd_b.en    = s1_hit_b || s2_hit_b;
    assign fwd_b.value = s1_hit_b ? ex.reg_value : s2_reg_value;

    assign op_a = a_pend_reg ? s2_reg_value : rd_a;
    assign op_b = b_pend_reg ? s2_reg_value : rd_b;

    ecu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (s2_valid_reg && m_ready && s2_res_reg.reg_we),
        .waddr   (s2_ra_reg),
        .wdata   (s2_reg_value),
        .re      (s_acc),
        .raddr_a (ra_in),
        .raddr_b (rb_in),
        .fwd_a   (fwd_a),
        .fwd_b   (fwd_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    ecu_exec #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_exec (
        .mode      (s1_mode_reg),
        .op_a      (op_a),
        .op_b      (op_b),
        .immediate (s1_imm_reg),
        .next_pc   (s1_npc_reg),
        .flags_in  (flags_reg),
        .sp_in     (sp_reg),
        .sp_next   (sp_next),
        .res       (ex)
    );

    ecu_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (s1_adv && ex.mem_we),
        .waddr   (ex.mem_addr[AW-1:0]),
        .wdata   (ex.data),
        .re      (s1_adv && ex.mem_re),
        .raddr   (ex.mem_addr[AW-1:0]),
        .rdata   (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            flags_reg    <= 4'd0;
            sp_reg       <= AW'(MEM_DEPTH - 1);
        end else begin
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
                flags_reg    <= ex.flags;
                sp_reg       <= sp_next;
            end else if (m_ready) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_mode_reg <= s_mode;
            s1_ra_reg   <= ra_in;
            s1_imm_reg  <= s_immediate;
            s1_npc_reg  <= s_next_pc;
            a_pend_reg  <= s1_hit_a && ex.reg_from_mem;
            b_pend_reg  <= s1_hit_b && ex.reg_from_mem;
        end
        if (s1_adv) begin
            s2_res_reg <= ex;
            s2_ra_reg  <= s1_ra_reg;
        end
    end

    assign m_valid       = s2_valid_reg;
    assign m_pc_out      = s2_res_reg.pc_from_mem ? mem_rdata : s2_res_reg.pc;
    assign m_flags       = s2_res_reg.flags;
    assign m_mem_write   = s2_res_reg.mem_we;
    assign m_mem_address = s2_res_reg.mem_addr;
    assign m_mem_data    = s2_res_reg.mem_re ? mem_rdata : s2_res_reg.data;
    assign m_reg_value   = s2_reg_value;

endmodule

>>> design/ecu_checker.sv
module ecu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_pc_out,
    input logic [3:0] m_flags,
    input logic       m_mem_write,
    input logic [7:0] m_mem_address,
    input logic [7:0] m_mem_data,
    input logic [7:0] m_reg_value
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pc_out) && $stable(m_flags)
            && $stable(m_mem_write) && $stable(m_mem_address) && $stable(m_mem_data)
            && $stable(m_reg_value))
        else $error("Result item changed while stalled.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input not ready while the result stage is empty.");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("Accepted item did not reach the result stage in time.");

endmodule

bind eight_bit_cpu_execute_unit_core ecu_checker u_ecu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pc_out      (m_pc_out),
    .m_flags       (m_flags),
    .m_mem_write   (m_mem_write),
    .m_mem_address (m_mem_address),
    .m_mem_data    (m_mem_data),
    .m_reg_value   (m_reg_value)
);

>>> tb/ecu_result_checker.sv
`timescale 1ns / 1ps

module ecu_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [3:0] s_mode,
    input  logic [2:0] s_reg_a,
    input  logic [2:0] s_reg_b,
    input  logic [7:0] s_immediate,
    input  logic [7:0] s_next_pc,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_pc_out,
    input  logic [3:0] m_flags,
    input  logic       m_mem_write,
    input  logic [7:0] m_mem_address,
    input  logic [7:0] m_mem_data,
    input  logic [7:0] m_reg_value,
    output int         mismatch_count,
    output int         pending_count
);
    import ecu_pkg::*;

    typedef struct packed {
        logic [7:0] pc_out;
        logic [3:0] flags;
        logic       mem_write;
        logic [7:0] mem_address;
        logic [7:0] mem_data;
        logic [7:0] reg_value;
    } exec_result_t;

    logic [7:0]   gpr [REG_COUNT_DEF];
    logic [3:0]   status;
    logic [7:0]   sp;
    logic [7:0]   dmem [MEM_DEPTH_DEF];
    exec_result_t expected_results[$];
    exec_result_t predicted;
    exec_result_t want;

    task automatic execute_instruction(input logic [3:0] mode, input logic [2:0] ra,
                                       input logic [2:0] rb, input logic [7:0] imm,
                                       input logic [7:0] npc, output exec_result_t res);
        logic [7:0] a;
        logic [7:0] r;
        logic       c;
        res = '0;
        res.pc_out = npc;
        a = gpr[ra];
        c = status[FLAG_C];
        case (mode)
            MODE_ST, MODE_STS: begin
                res.mem_address = (mode == MODE_ST) ? gpr[rb] : imm;
                res.mem_data = gpr[ra];
                res.mem_write = 1'b1;
                dmem[res.mem_address] = res.mem_data;
            end
            MODE_LD, MODE_LDS: begin
                // The address comes from register B before register A is written.
                res.mem_address = (mode == MODE_LD) ? gpr[rb] : imm;
                res.mem_data = dmem[res.mem_address];
                gpr[ra] = res.mem_data;
            end
            MODE_CALL: begin
                res.mem_address = sp;
                res.mem_data = npc;
                res.mem_write = 1'b1;
                dmem[sp] = npc;
                sp = (sp == 0) ? 8'(MEM_DEPTH_DEF - 1) : sp - 8'd1;
                res.pc_out = imm;
            end
            MODE_RET: begin
                sp = (int'(sp) + 1 >= MEM_DEPTH_DEF) ? 8'd0 : sp + 8'd1;
                res.mem_address = sp;
                res.mem_data = dmem[sp];
                res.pc_out = dmem[sp];
            end
            MODE_CLC: status[FLAG_C] = 1'b0;
            MODE_SEC: status[FLAG_C] = 1'b1;
            MODE_ROR: begin
                r = {c, a[DATA_MSB:1]};
                status[FLAG_V] = a[DATA_MSB] ^ c;
                status[FLAG_N] = c;
                status[FLAG_Z] = (r == 8'd0);
                status[FLAG_C] = a[0];
                gpr[ra] = r;
            end
            MODE_ROL: begin
                r = {a[DATA_MSB_M1:0], c};
                status[FLAG_V] = a[DATA_MSB] ^ a[DATA_MSB_M1];
                status[FLAG_N] = a[DATA_MSB_M1];
                status[FLAG_Z] = (r == 8'd0);
                status[FLAG_C] = a[DATA_MSB];
                gpr[ra] = r;
            end
            default: ;
        endcase
        res.flags = status;
        res.reg_value = gpr[ra];
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT_DEF; i++) gpr[i] = 8'd0;
            for (int i = 0; i < MEM_DEPTH_DEF; i++) dmem[i] = 8'd0;
            status = 4'd0;
            sp = 8'(MEM_DEPTH_DEF - 1);
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                execute_instruction(s_mode, s_reg_a, s_reg_b, s_immediate, s_next_pc,
                                    predicted);
                expected_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item, pc_out", int'(m_pc_out), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_pc_out !== want.pc_out)
                        report_mismatch("pc_out", int'(m_pc_out), int'(want.pc_out));
                    if (m_flags !== want.flags)
                        report_mismatch("flags", int'(m_flags), int'(want.flags));
                    if (m_mem_write !== want.mem_write)
                        report_mismatch("mem_write", int'(m_mem_write),
                                        int'(want.mem_write));
                    if (m_mem_address !== want.mem_address)
                        report_mismatch("mem_address", int'(m_mem_address),
                                        int'(want.mem_address));
                    if (m_mem_data !== want.mem_data)
                        report_mismatch("mem_data", int'(m_mem_data), int'(want.mem_data));
                    if (m_reg_value !== want.reg_value)
                        report_mismatch("reg_value", int'(m_reg_value),
                                        int'(want.reg_value));
                end
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

>>> tb/eight_bit_cpu_execute_unit_core_test.sv
`timescale 1ns / 1ps

module eight_bit_cpu_execute_unit_core_test;
    import ecu_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam logic [3:0] FIRST_UNUSED_MODE = MODE_ROL + 4'd1;
    localparam logic [3:0] MODE_FIELD_MAX = 4'hF;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [3:0] s_mode = '0;
    logic [2:0] s_reg_a = '0;
    logic [2:0] s_reg_b = '0;
    logic [7:0] s_immediate = '0;
    logic [7:0] s_next_pc = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_pc_out;
    logic [3:0] m_flags;
    logic       m_mem_write;
    logic [7:0] m_mem_address;
    logic [7:0] m_mem_data;
    logic [7:0] m_reg_value;

    int mismatch_count;
    int pending_count;
    int send_idle_pct = 6;
    int recv_idle_pct = 68;
    int stall_cycles = 0;

    eight_bit_cpu_execute_unit_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_reg_a(s_reg_a),
        .s_reg_b(s_reg_b), .s_immediate(s_immediate), .s_next_pc(s_next_pc),
        .m_valid(m_valid), .m_ready(m_ready), .m_pc_out(m_pc_out), .m_flags(m_flags),
        .m_mem_write(m_mem_write), .m_mem_address(m_mem_address),
        .m_mem_data(m_mem_data), .m_reg_value(m_reg_value)
    );

    ecu_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_reg_a(s_reg_a),
        .s_reg_b(s_reg_b), .s_immediate(s_immediate), .s_next_pc(s_next_pc),
        .m_valid(m_valid), .m_ready(m_ready), .m_pc_out(m_pc_out), .m_flags(m_flags),
        .m_mem_write(m_mem_write), .m_mem_address(m_mem_address),
        .m_mem_data(m_mem_data), .m_reg_value(m_reg_value),
        .mismatch_count(mismatch_count), .pending_count(pending_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("eight_bit_cpu_execute_unit_core_test: FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [3:0] mode, input logic [2:0] ra,
                             input logic [2:0] rb, input logic [7:0] imm,
                             input logic [7:0] npc);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_reg_a <= ra;
        s_reg_b <= rb;
        s_immediate <= imm;
        s_next_pc <= npc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_item();
        logic [3:0] mode;
        logic [7:0] imm;
        if ($urandom_range(0, 99) < 8) begin
            mode = 4'($urandom_range(FIRST_UNUSED_MODE, MODE_FIELD_MAX));
        end else begin
            mode = 4'($urandom_range(MODE_ST, MODE_ROL));
        end
        // Small addresses make loads hit bytes that earlier stores wrote.
        imm = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        send_item(mode, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), imm,
                  8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(MODE_CALL, 3'd0, 3'd0, 8'h00, 8'hFF);
        send_item(MODE_LDS,  3'd7, 3'd0, 8'hFF, 8'h01);
        send_item(MODE_STS,  3'd7, 3'd0, 8'h00, 8'h02);
        send_item(MODE_ST,   3'd7, 3'd7, 8'h00, 8'h03);
        send_item(MODE_LD,   3'd6, 3'd7, 8'h00, 8'h04);
        send_item(MODE_LD,   3'd7, 3'd7, 8'h00, 8'h05);
        send_item(MODE_ROR,  3'd7, 3'd0, 8'h00, 8'h06);
        send_item(MODE_ROL,  3'd6, 3'd0, 8'h00, 8'h07);
        send_item(MODE_CLC,  3'd0, 3'd0, 8'h00, 8'h08);
        send_item(MODE_ROL,  3'd0, 3'd0, 8'h00, 8'h09);
        send_item(MODE_SEC,  3'd0, 3'd0, 8'h00, 8'h0A);
        send_item(MODE_ROR,  3'd0, 3'd0, 8'h00, 8'h0B);
        send_item(MODE_RET,  3'd0, 3'd0, 8'h00, 8'h0C);
        send_item(MODE_RET,  3'd0, 3'd0, 8'h00, 8'h0D);
        send_item(MODE_CALL, 3'd0, 3'd0, 8'hFF, 8'h00);
        send_item(MODE_CALL, 3'd0, 3'd0, 8'h5A, 8'hA5);
        send_item(FIRST_UNUSED_MODE, 3'd7, 3'd7, 8'hFF, 8'hFF);
        send_item(MODE_FIELD_MAX,    3'd0, 3'd0, 8'h00, 8'h00);
        send_item(MODE_LDS,  3'd1, 3'd0, 8'h80, 8'h10);
        send_item(MODE_ST,   3'd5, 3'd5, 8'h00, 8'h11);
        send_item(MODE_ROL,  3'd5, 3'd0, 8'h00, 8'h12);

        for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
        send_idle_pct = 68;
        recv_idle_pct = 6;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("eight_bit_cpu_execute_unit_core_test: PASS");
        end else begin
            $display("eight_bit_cpu_execute_unit_core_test: FAIL");
        end
        $finish;
    end

endmodule
